// File: rtl/core/svacc_pkg.sv
// Shared types, constants and helper functions for the scaled vector accumulate pipeline.
// No dependencies; imported by every module under rtl/core.
`default_nettype none
package svacc_pkg;

  // Signed exponent; wide enough for product exponents of normalized subnormals.
  typedef logic signed [13:0] exp_t;

  localparam logic [63:0] QNAN     = 64'h7FF8_0000_0000_0000;
  localparam int          WIN      = 162;  // accumulation window width
  localparam int          ADD_POS  = 108;  // addend LSB position at zero alignment shift
  localparam logic [7:0]  SH_CAP   = 8'd200;
  localparam logic [7:0]  RSH_CAP  = 8'd170;

  // After unpack / special-case detection
  typedef struct packed {
    logic        last;
    logic        spec;
    logic [63:0] spec_val;
    logic        sp;
    logic        sc;
    logic        czero;
    logic [52:0] ma;
    logic [52:0] mb;
    logic [52:0] mc;
    exp_t        ea;
    exp_t        eb;
    exp_t        ec;
  } unp_t;

  // Partial products and aligned addend
  typedef struct packed {
    logic             last;
    logic             spec;
    logic [63:0]      spec_val;
    logic             sp;
    logic             sc;
    logic [53:0]      p_ll;
    logic [52:0]      p_lh;
    logic [52:0]      p_hl;
    logic [51:0]      p_hh;
    logic [WIN-1:0]   addend;
    exp_t             e0;
  } mul_t;

  // Full product
  typedef struct packed {
    logic           last;
    logic           spec;
    logic [63:0]    spec_val;
    logic           sp;
    logic           sc;
    logic [105:0]   prod;
    logic [WIN-1:0] addend;
    exp_t           e0;
  } prd_t;

  // Signed-magnitude sum
  typedef struct packed {
    logic           last;
    logic           spec;
    logic [63:0]    spec_val;
    logic           sign;
    logic           zero;
    logic [WIN-1:0] mag;
    exp_t           e0;
  } sum_t;

  // Leading-one position resolved into a shift
  typedef struct packed {
    logic           last;
    logic           spec;
    logic [63:0]    spec_val;
    logic           sign;
    logic           zero;
    logic           ovf;
    logic [WIN-1:0] mag;
    exp_t           biased;
    logic           lshift;
    logic [7:0]     amt;
  } lzn_t;

  // Normalized significand ready to round
  typedef struct packed {
    logic           last;
    logic           spec;
    logic [63:0]    spec_val;
    logic           sign;
    logic           zero;
    logic           ovf;
    logic [WIN-1:0] nrm;
    logic           rst;
    exp_t           biased;
  } nrm_t;

  function automatic logic [5:0] lzc53(input logic [52:0] v);
    logic [5:0] n;
    n = 6'd53;
    for (int i = 0; i < 53; i++) begin
      if (v[i]) n = 6'(52 - i);
    end
    return n;
  endfunction

  function automatic logic [7:0] msb_pos(input logic [WIN-1:0] v);
    logic [7:0] p;
    p = 8'd0;
    for (int i = 0; i < WIN; i++) begin
      if (v[i]) p = 8'(i);
    end
    return p;
  endfunction

endpackage
`default_nettype wire

// File: rtl/core/svacc_front.sv
// Front end: operand unpack, special cases, subnormal normalize (stage 1),
// partial products and addend alignment (stage 2). Uses svacc_pkg.
`default_nettype none
module svacc_front import svacc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] alpha,
  input  logic [63:0] x_value,
  input  logic [63:0] y_value,
  input  logic        last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output mul_t        out_item
);

  logic v1_r, v2_r, en1, en2;
  unp_t s1_r, s1_nxt;
  mul_t s2_r, s2_nxt;

  assign en2       = !v2_r || out_ready;
  assign en1       = !v1_r || en2;
  assign in_ready  = en1;
  assign out_valid = v2_r;
  assign out_item  = s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) s1_r <= s1_nxt;
    if (en2 && v1_r)     s2_r <= s2_nxt;
  end

  // stage 1
  logic [10:0] exa, exb, exc;
  logic [51:0] fa, fb, fc;
  logic nan_a, nan_b, nan_c, inf_a, inf_b, inf_c, zero_a, zero_b, zero_c;
  logic [5:0]  lza, lzb;

  assign exa = alpha[62:52];
  assign exb = x_value[62:52];
  assign exc = y_value[62:52];
  assign fa  = alpha[51:0];
  assign fb  = x_value[51:0];
  assign fc  = y_value[51:0];
  assign nan_a  = (&exa) && (|fa);
  assign nan_b  = (&exb) && (|fb);
  assign nan_c  = (&exc) && (|fc);
  assign inf_a  = (&exa) && !(|fa);
  assign inf_b  = (&exb) && !(|fb);
  assign inf_c  = (&exc) && !(|fc);
  assign zero_a = !(|alpha[62:0]);
  assign zero_b = !(|x_value[62:0]);
  assign zero_c = !(|y_value[62:0]);
  assign lza    = lzc53({1'b0, fa});
  assign lzb    = lzc53({1'b0, fb});

  always_comb begin
    logic sp;
    sp = alpha[63] ^ x_value[63];
    s1_nxt          = '0;
    s1_nxt.last     = last_in;
    s1_nxt.sp       = sp;
    s1_nxt.sc       = y_value[63];
    s1_nxt.czero    = zero_c;
    s1_nxt.spec     = 1'b1;
    s1_nxt.spec_val = QNAN;
    // alpha of either zero passes y untouched, ahead of every other case
    if (zero_a) begin
      s1_nxt.spec_val = y_value;
    end else if (nan_a || nan_b || nan_c) begin
      s1_nxt.spec_val = QNAN;
    end else if (inf_a || inf_b) begin
      if (zero_b || (inf_c && (y_value[63] != sp))) s1_nxt.spec_val = QNAN;
      else s1_nxt.spec_val = {sp, 11'h7FF, 52'd0};
    end else if (inf_c) begin
      s1_nxt.spec_val = y_value;
    end else if (zero_b) begin
      s1_nxt.spec_val = zero_c ? {sp & y_value[63], 63'd0} : y_value;
    end else begin
      s1_nxt.spec = 1'b0;
    end

    if (exa == 11'd0) begin
      s1_nxt.ma = {1'b0, fa} << lza;
      s1_nxt.ea = exp_t'(-1074) - exp_t'({8'd0, lza});
    end else begin
      s1_nxt.ma = {1'b1, fa};
      s1_nxt.ea = exp_t'({3'd0, exa}) - exp_t'(1075);
    end
    if (exb == 11'd0) begin
      s1_nxt.mb = {1'b0, fb} << lzb;
      s1_nxt.eb = exp_t'(-1074) - exp_t'({8'd0, lzb});
    end else begin
      s1_nxt.mb = {1'b1, fb};
      s1_nxt.eb = exp_t'({3'd0, exb}) - exp_t'(1075);
    end
    // y stays unnormalized; its LSB weight is fixed for subnormals
    s1_nxt.mc = {(exc != 11'd0), fc};
    s1_nxt.ec = (exc == 11'd0) ? exp_t'(-1074) : exp_t'({3'd0, exc}) - exp_t'(1075);
  end

  // stage 2
  always_comb begin
    exp_t           ep, shr;
    logic [7:0]     sh;
    logic [WIN-1:0] full, sft;
    ep  = s1_r.ea + s1_r.eb;
    shr = exp_t'(ADD_POS) + ep - s1_r.ec;
    s2_nxt.e0 = ep;
    if (s1_r.czero) begin
      sh = SH_CAP;
    end else if (shr < 0) begin
      // addend far above the product: product only matters as a sticky effect
      sh = 8'd0;
      s2_nxt.e0 = s1_r.ec - exp_t'(ADD_POS);
    end else if (shr > exp_t'({6'd0, SH_CAP})) begin
      sh = SH_CAP;
    end else begin
      sh = shr[7:0];
    end
    full = {1'b0, s1_r.mc, 108'd0};
    sft  = full >> sh;
    s2_nxt.addend   = sft | {{(WIN-1){1'b0}}, ((sft << sh) != full)};
    s2_nxt.last     = s1_r.last;
    s2_nxt.spec     = s1_r.spec;
    s2_nxt.spec_val = s1_r.spec_val;
    s2_nxt.sp       = s1_r.sp;
    s2_nxt.sc       = s1_r.sc;
    s2_nxt.p_ll     = s1_r.ma[26:0]  * s1_r.mb[26:0];
    s2_nxt.p_lh     = s1_r.ma[26:0]  * s1_r.mb[52:27];
    s2_nxt.p_hl     = s1_r.ma[52:27] * s1_r.mb[26:0];
    s2_nxt.p_hh     = s1_r.ma[52:27] * s1_r.mb[52:27];
  end

endmodule
`default_nettype wire

// File: rtl/core/svacc_sum.sv
// Product assembly from partial products (stage 3) and the wide
// signed-magnitude add of product and aligned addend (stage 4). Uses svacc_pkg.
`default_nettype none
module svacc_sum import svacc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  mul_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output sum_t out_item
);

  logic v3_r, v4_r, en3, en4;
  prd_t s3_r, s3_nxt;
  sum_t s4_r, s4_nxt;

  assign en4       = !v4_r || out_ready;
  assign en3       = !v3_r || en4;
  assign in_ready  = en3;
  assign out_valid = v4_r;
  assign out_item  = s4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en3) v3_r <= in_valid;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && in_valid) s3_r <= s3_nxt;
    if (en4 && v3_r)     s4_r <= s4_nxt;
  end

  always_comb begin
    logic [53:0] mid;
    mid = {1'b0, in_item.p_lh} + {1'b0, in_item.p_hl};
    s3_nxt.prod = {in_item.p_hh, 54'd0} + {25'd0, mid, 27'd0} + {52'd0, in_item.p_ll};
    s3_nxt.last     = in_item.last;
    s3_nxt.spec     = in_item.spec;
    s3_nxt.spec_val = in_item.spec_val;
    s3_nxt.sp       = in_item.sp;
    s3_nxt.sc       = in_item.sc;
    s3_nxt.addend   = in_item.addend;
    s3_nxt.e0       = in_item.e0;
  end

  always_comb begin
    logic [WIN:0] pw, aw, diff;
    pw   = {57'd0, s3_r.prod};
    aw   = {1'b0, s3_r.addend};
    diff = aw - pw;
    s4_nxt.last     = s3_r.last;
    s4_nxt.spec     = s3_r.spec;
    s4_nxt.spec_val = s3_r.spec_val;
    s4_nxt.e0       = s3_r.e0;
    s4_nxt.zero     = 1'b0;
    if (s3_r.sp == s3_r.sc) begin
      s4_nxt.mag  = s3_r.addend + pw[WIN-1:0];
      s4_nxt.sign = s3_r.sp;
    end else if (diff[WIN]) begin
      s4_nxt.mag  = pw[WIN-1:0] - s3_r.addend;
      s4_nxt.sign = s3_r.sp;
    end else begin
      s4_nxt.mag  = diff[WIN-1:0];
      s4_nxt.sign = s3_r.sc;
      s4_nxt.zero = (diff == '0);  // exact cancellation gives +0
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/svacc_norm.sv
// Leading-one search and exponent/shift decision (stage 5), then the
// normalizing or denormalizing shift with sticky collection (stage 6). Uses svacc_pkg.
`default_nettype none
module svacc_norm import svacc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sum_t in_item,
  output logic out_valid,
  input  logic out_ready,
  output nrm_t out_item
);

  logic v5_r, v6_r, en5, en6;
  lzn_t s5_r, s5_nxt;
  nrm_t s6_r, s6_nxt;

  assign en6       = !v6_r || out_ready;
  assign en5       = !v5_r || en6;
  assign in_ready  = en5;
  assign out_valid = v6_r;
  assign out_item  = s6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
    end else begin
      if (en5) v5_r <= in_valid;
      if (en6) v6_r <= v5_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en5 && in_valid) s5_r <= s5_nxt;
    if (en6 && v5_r)     s6_r <= s6_nxt;
  end

  always_comb begin
    logic [7:0] m;
    exp_t       biased, lsh, nl;
    m      = msb_pos(in_item.mag);
    biased = in_item.e0 + exp_t'({6'd0, m}) + exp_t'(1023);
    lsh    = exp_t'(1183) + in_item.e0;  // puts weight 2^-1074 at the rounding LSB
    nl     = -lsh;
    s5_nxt.last     = in_item.last;
    s5_nxt.spec     = in_item.spec;
    s5_nxt.spec_val = in_item.spec_val;
    s5_nxt.sign     = in_item.sign;
    s5_nxt.zero     = in_item.zero;
    s5_nxt.mag      = in_item.mag;
    s5_nxt.biased   = biased;
    s5_nxt.ovf      = biased > exp_t'(2046);
    if (biased >= exp_t'(1)) begin
      s5_nxt.lshift = 1'b1;
      s5_nxt.amt    = 8'd161 - m;
    end else if (lsh >= 0) begin
      s5_nxt.lshift = 1'b1;
      s5_nxt.amt    = lsh[7:0];
    end else begin
      s5_nxt.lshift = 1'b0;
      s5_nxt.amt    = (nl > exp_t'({6'd0, RSH_CAP})) ? RSH_CAP : nl[7:0];
    end
  end

  always_comb begin
    logic [WIN-1:0] rs;
    rs = s5_r.mag >> s5_r.amt;
    s6_nxt.last     = s5_r.last;
    s6_nxt.spec     = s5_r.spec;
    s6_nxt.spec_val = s5_r.spec_val;
    s6_nxt.sign     = s5_r.sign;
    s6_nxt.zero     = s5_r.zero;
    s6_nxt.ovf      = s5_r.ovf;
    s6_nxt.biased   = s5_r.biased;
    if (s5_r.lshift) begin
      s6_nxt.nrm = s5_r.mag << s5_r.amt;
      s6_nxt.rst = 1'b0;
    end else begin
      s6_nxt.nrm = rs;
      s6_nxt.rst = ((rs << s5_r.amt) != s5_r.mag);
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/svacc_round.sv
// Round to nearest even and binary64 pack into the output register (stage 7).
// Uses svacc_pkg.
`default_nettype none
module svacc_round import svacc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  nrm_t        in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] y_result,
  output logic        last_out
);

  logic        v7_r, en7;
  logic [63:0] res_r, res_nxt;
  logic        last_r;

  assign en7       = !v7_r || out_ready;
  assign in_ready  = en7;
  assign out_valid = v7_r;
  assign y_result  = res_r;
  assign last_out  = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v7_r <= 1'b0;
    else if (en7) v7_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en7 && in_valid) begin
      res_r  <= res_nxt;
      last_r <= in_item.last;
    end
  end

  always_comb begin
    logic [52:0] q;
    logic        g, st, rnd;
    logic [53:0] q1;
    exp_t        bm1;
    q   = in_item.nrm[161:109];
    g   = in_item.nrm[108];
    st  = (|in_item.nrm[107:0]) | in_item.rst;
    rnd = g & (st | q[0]);
    q1  = {1'b0, q} + {53'd0, rnd};
    bm1 = in_item.biased - exp_t'(1);
    if (in_item.spec) begin
      res_nxt = in_item.spec_val;
    end else if (in_item.zero) begin
      res_nxt = 64'd0;
    end else if (in_item.ovf) begin
      res_nxt = {in_item.sign, 11'h7FF, 52'd0};
    end else if (in_item.biased >= exp_t'(1)) begin
      // a rounding carry out of the significand bumps the exponent field
      res_nxt = {in_item.sign, {bm1[10:0], 52'd0} + {9'd0, q1}};
    end else begin
      res_nxt = {in_item.sign, 9'd0, q1};
    end
  end

`ifndef NO_ASSERTIONS
  a_norm_msb: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_item.spec && !in_item.zero && !in_item.ovf &&
     (in_item.biased >= exp_t'(1))) |-> in_item.nrm[161])
    else $error("normal-range significand not normalized");
`endif

endmodule
`default_nettype wire

// File: rtl/core/scaled_vector_accumulate_top.sv
// Pipeline: seven register stages, the first loaded at the input transfer edge.
// Throughput: one x/y element pair per cycle when not stalled; each pipeline stage
// holds its item under stall and accepts a new one as soon as it empties.
// Reset: synchronous active-low rst_n clears all stage valid bits and alpha to +0.0.
// Depends on svacc_pkg and svacc_front, svacc_sum, svacc_norm, svacc_round.
`default_nettype none
module scaled_vector_accumulate_top import svacc_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,   // [63:0] x_value, [127:64] y_value
  input  logic         in_tlast,   // last_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [63:0]  out_tdata,  // [63:0] y_result
  output logic         out_tlast,  // last_out
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [63:0]  cfg_data    // alpha_bits
);

  logic [63:0] alpha_r;
  logic        f_valid, f_ready, s_valid, s_ready, n_valid, n_ready;
  mul_t        f_item;
  sum_t        s_item;
  nrm_t        n_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) alpha_r <= 64'd0;
    else if (cfg_valid) alpha_r <= cfg_data;
  end

  svacc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .alpha     (alpha_r),
    .x_value   (in_tdata[63:0]),
    .y_value   (in_tdata[127:64]),
    .last_in   (in_tlast),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  svacc_sum u_sum (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_item  (s_item)
  );

  svacc_norm u_norm (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_item   (s_item),
    .out_valid (n_valid),
    .out_ready (n_ready),
    .out_item  (n_item)
  );

  svacc_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (n_valid),
    .in_ready  (n_ready),
    .in_item   (n_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .y_result  (out_tdata),
    .last_out  (out_tlast)
  );

`ifndef NO_ASSERTIONS
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output side is ready");
  a_empty_tail: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output stage");
`endif

endmodule
`default_nettype wire
